// ===== rtl/fbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrf_pkg
// Types and constants for the factor base root finder.
// ----------------------------------------------------------------------------
package fbrf_pkg;

   localparam int PRIME_WIDTH = 16;
   localparam int INDEX_WIDTH = 10;
   localparam int STATUS_WIDTH = 3;
   localparam logic [INDEX_WIDTH-1:0] BASE_LIMIT_RESET = 10'd200;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_ACCEPTED    = 3'd0,
      STATUS_NOT_PRIME   = 3'd1,
      STATUS_DIVIDES     = 3'd2,
      STATUS_NON_RESIDUE = 3'd3,
      STATUS_NO_ROOT     = 3'd4,
      STATUS_BASE_FULL   = 3'd5
   } status_type;

   typedef struct packed {
      logic [PRIME_WIDTH-1:0] candidate;
      logic [PRIME_WIDTH-1:0] number_residue;
      logic [PRIME_WIDTH-1:0] start_residue;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [INDEX_WIDTH-1:0]  entry_index;
      logic [PRIME_WIDTH-1:0]  first_offset;
      logic [PRIME_WIDTH-1:0]  second_offset;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TD_SQ,
      ST_TD_CHK,
      ST_TD_REM,
      ST_MOD,
      ST_RED_N,
      ST_RED_S,
      ST_PW_CHK,
      ST_PW_ACC,
      ST_PW_BASE,
      ST_EULER,
      ST_SRCH_MUL,
      ST_SRCH_CHK,
      ST_OFFS,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/factor_base_root_finder_top.sv =====
// ----------------------------------------------------------------------------
// factor_base_root_finder_top
// Checks a candidate prime for a quadratic sieve factor base and finds the
// two sieve offsets from a modular square root of the number.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one candidate with the number and its ceiling square root,
//   both reduced by the candidate. A transfer happens when req_valid is high
//   and req_stall low; req_stall is high from that transfer until the result
//   has been taken. rsp_* carries status, entry index and both offsets, with
//   rsp_valid held until a cycle with rsp_stall low.
//   csr_* writes base_limit; csr_ready is always high.
// Timing: one shared multiplier forms every product and feeds a bit-serial
//   remainder unit. Trial division tries each odd divisor up to sqrt(p), then
//   the powers run square-and-multiply. For a prime of form 4k+1 the root
//   search tries values in turn and can run to (p-1)/2 of them. A full base,
//   an even candidate or one below 3 gives its result the cycle after the
//   transfer. One item is in work at once.
// Reset: accepted count clears, base_limit returns to 200, no result pending.
// A stalled result simply holds; the block takes no new item until it leaves.
// ----------------------------------------------------------------------------
module factor_base_root_finder_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  fbrf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fbrf_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [fbrf_pkg::INDEX_WIDTH-1:0] csr_data
);
   import fbrf_pkg::*;

   localparam int W = PRIME_WIDTH;
   localparam int CW = $clog2(2 * W);
   localparam logic [CW-1:0] MOD_LAST = CW'(2 * W - 1);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [INDEX_WIDTH-1:0] limit_ff, limit_in, count_ff, count_in, index_ff, index_in;
   logic [W-1:0] p_ff, p_in, n_ff, n_in, s_ff, s_in;
   logic [W-1:0] d_ff, d_in, acc_ff, acc_in, base_ff, base_in, e_ff, e_in;
   logic [W-1:0] t_ff, t_in, off1_ff, off1_in, off2_ff, off2_in;
   logic [W-1:0] div_ff, div_in, rem_ff, rem_in;
   logic [2*W-1:0] dvd_ff, dvd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic phase_ff, phase_in;

   logic [W-1:0] mul_a, mul_b, mod_div;
   logic [2*W-1:0] mul_prod;
   logic mod_start;
   logic [W:0] rem_shift;
   logic [W:0] p_inc;
   logic [W+1:0] x1, x2, p_ext;

   // shared multiplier
   assign mul_prod = mul_a * mul_b;

   // one restoring remainder step
   assign rem_shift = {rem_ff, dvd_ff[2*W-1]};
   assign p_inc = {1'b0, p_ff} + (W+1)'(1);
   assign p_ext = {2'b00, p_ff};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign csr_ready = 1'b1;
   assign rsp_data.status = status_ff;
   assign rsp_data.entry_index = index_ff;
   assign rsp_data.first_offset = off1_ff;
   assign rsp_data.second_offset = off2_ff;

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= BASE_LIMIT_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         count_ff <= count_in;
      end
      ret_ff <= ret_in;
      index_ff <= index_in;
      p_ff <= p_in;
      n_ff <= n_in;
      s_ff <= s_in;
      d_ff <= d_in;
      acc_ff <= acc_in;
      base_ff <= base_in;
      e_ff <= e_in;
      t_ff <= t_in;
      off1_ff <= off1_in;
      off2_ff <= off2_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      status_ff <= status_in;
      phase_ff <= phase_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;
      count_in = count_ff;
      index_in = index_ff;
      p_in = p_ff;
      n_in = n_ff;
      s_in = s_ff;
      d_in = d_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      e_in = e_ff;
      t_in = t_ff;
      off1_in = off1_ff;
      off2_in = off2_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      status_in = status_ff;
      phase_in = phase_ff;
      mul_a = p_ff;
      mul_b = W'(1);
      mod_div = p_ff;
      mod_start = 1'b0;
      x1 = '0;
      x2 = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               p_in = req_data.candidate;
               n_in = req_data.number_residue;
               s_in = req_data.start_residue;
               index_in = count_ff;
               off1_in = '0;
               off2_in = '0;
               d_in = W'(3);
               if (count_ff >= limit_ff) begin
                  status_in = STATUS_BASE_FULL;
                  state_in = ST_OUT;
               end else if (req_data.candidate < W'(3) || !req_data.candidate[0]) begin
                  status_in = STATUS_NOT_PRIME;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_TD_SQ;
               end
            end
         end
         // square the trial divisor
         ST_TD_SQ: begin
            mul_a = d_ff;
            mul_b = d_ff;
            dvd_in = mul_prod;
            state_in = ST_TD_CHK;
         end
         ST_TD_CHK: begin
            if (dvd_ff > {{W{1'b0}}, p_ff}) begin
               mul_a = n_ff;
               mod_start = 1'b1;
               ret_in = ST_RED_N;
            end else begin
               mul_a = p_ff;
               mod_div = d_ff;
               mod_start = 1'b1;
               ret_in = ST_TD_REM;
            end
         end
         ST_TD_REM: begin
            if (rem_ff == '0) begin
               status_in = STATUS_NOT_PRIME;
               state_in = ST_OUT;
            end else begin
               d_in = d_ff + W'(2);
               state_in = ST_TD_SQ;
            end
         end
         // bit-serial remainder, one dividend bit per cycle
         ST_MOD: begin
            rem_in = (rem_shift >= {1'b0, div_ff}) ? W'(rem_shift - {1'b0, div_ff})
                                                   : rem_shift[W-1:0];
            dvd_in = {dvd_ff[2*W-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) state_in = ret_ff;
         end
         ST_RED_N: begin
            n_in = rem_ff;
            mul_a = s_ff;
            mod_start = 1'b1;
            ret_in = ST_RED_S;
         end
         ST_RED_S: begin
            s_in = rem_ff;
            if (n_ff == '0) begin
               status_in = STATUS_DIVIDES;
               state_in = ST_OUT;
            end else begin
               base_in = n_ff;
               e_in = {1'b0, p_ff[W-1:1]};
               acc_in = W'(1);
               phase_in = 1'b0;
               state_in = ST_PW_CHK;
            end
         end
         // square-and-multiply
         ST_PW_CHK: begin
            if (e_ff == '0) begin
               state_in = phase_ff ? ST_OFFS : ST_EULER;
            end else if (e_ff[0]) begin
               mul_a = acc_ff;
               mul_b = base_ff;
               mod_start = 1'b1;
               ret_in = ST_PW_ACC;
            end else begin
               mul_a = base_ff;
               mul_b = base_ff;
               mod_start = 1'b1;
               ret_in = ST_PW_BASE;
            end
         end
         ST_PW_ACC: begin
            acc_in = rem_ff;
            mul_a = base_ff;
            mul_b = base_ff;
            mod_start = 1'b1;
            ret_in = ST_PW_BASE;
         end
         ST_PW_BASE: begin
            base_in = rem_ff;
            e_in = {1'b0, e_ff[W-1:1]};
            state_in = ST_PW_CHK;
         end
         ST_EULER: begin
            if (acc_ff != W'(1)) begin
               status_in = STATUS_NON_RESIDUE;
               state_in = ST_OUT;
            end else if (p_ff[1:0] == 2'b11) begin
               base_in = n_ff;
               e_in = {1'b0, p_inc[W:2]};
               acc_in = W'(1);
               phase_in = 1'b1;
               state_in = ST_PW_CHK;
            end else begin
               t_in = W'(1);
               state_in = ST_SRCH_MUL;
            end
         end
         // linear root search
         ST_SRCH_MUL: begin
            mul_a = t_ff;
            mul_b = t_ff;
            mod_start = 1'b1;
            ret_in = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            if (rem_ff == n_ff) begin
               acc_in = t_ff;
               state_in = ST_OFFS;
            end else if (t_ff + W'(1) == p_ff) begin
               status_in = STATUS_NO_ROOT;
               state_in = ST_OUT;
            end else begin
               t_in = t_ff + W'(1);
               state_in = ST_SRCH_MUL;
            end
         end
         // root is in acc, form both offsets
         ST_OFFS: begin
            x1 = {2'b00, acc_ff} + p_ext - {2'b00, s_ff};
            if (x1 >= p_ext) x1 = x1 - p_ext;
            x2 = (p_ext << 1) - {2'b00, acc_ff} - {2'b00, s_ff};
            if (x2 >= p_ext) x2 = x2 - p_ext;
            if (x2 >= p_ext) x2 = x2 - p_ext;
            off1_in = x1[W-1:0];
            off2_in = x2[W-1:0];
            status_in = STATUS_ACCEPTED;
            count_in = count_ff + INDEX_WIDTH'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // launch a reduction of the product
      if (mod_start) begin
         dvd_in = mul_prod;
         div_in = mod_div;
         rem_in = '0;
         cnt_in = MOD_LAST;
         state_in = ST_MOD;
      end
   end

endmodule
